/* rtl/core/dqs_pkg.sv */
package dqs_pkg;

  // Storage defaults and word width
  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;

  // Command kinds as they arrive on the input word
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_DUMP       = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  // Back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_DUMP
  } bk_state_t;

  // Input word
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Output word
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } res_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } work_t;

endpackage

/* rtl/core/dqs_front.sv */
module dqs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dqs_pkg::cmd_t cmd,
  output dqs_pkg::work_t work,
  input  logic          take
);
  import dqs_pkg::*;

  localparam logic [1:0] QFULL = 2'd2;

  op_t                      q_op  [2];
  logic signed [DATA_W-1:0] q_val [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               fill;

  op_t  op_in;
  logic kind_ok;
  logic enq;
  logic deq;

  // Classify the incoming kind; drop codes that mean nothing
  always_comb begin
    kind_ok = 1'b1;
    op_in   = OP_PUSH_FRONT;
    unique case (cmd.kind)
      KIND_PUSH_FRONT: op_in = OP_PUSH_FRONT;
      KIND_PUSH_BACK:  op_in = OP_PUSH_BACK;
      KIND_POP_FRONT:  op_in = OP_POP_FRONT;
      KIND_POP_BACK:   op_in = OP_POP_BACK;
      KIND_DUMP:       op_in = OP_DUMP;
      default:         kind_ok = 1'b0;
    endcase
  end

  assign busy = (fill == QFULL);
  assign enq  = start && !busy && kind_ok;
  assign deq  = take;

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (deq) rd_ptr <= ~rd_ptr;
      unique case ({enq, deq})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (enq) begin
      q_op[wr_ptr]  <= op_in;
      q_val[wr_ptr] <= cmd.value;
    end
  end

  assign work.valid = (fill != 2'd0);
  assign work.op    = q_op[rd_ptr];
  assign work.value = q_val[rd_ptr];

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= QFULL)
    else $error("command queue fill out of range");
  a_no_enq_full: assert property (@(posedge clk) disable iff (rst) enq |-> fill != QFULL)
    else $error("enqueue into full command queue");
  a_no_deq_empty: assert property (@(posedge clk) disable iff (rst) deq |-> fill != 2'd0)
    else $error("dequeue from empty command queue");
`endif

endmodule

/* rtl/core/dqs_back.sv */
module dqs_back #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  dqs_pkg::work_t work,
  output logic           take,
  output logic           strobe,
  output dqs_pkg::res_t  result
);
  import dqs_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam logic [CntW-1:0] CNT_FULL  = CntW'(DEPTH);
  localparam logic [CntW-1:0] CNT_ONE   = CntW'(1);
  localparam logic [IdxW-1:0] IDX_LAST  = IdxW'(DEPTH - 1);
  localparam logic [SumW-1:0] SUM_DEPTH = SumW'(DEPTH);

  // Ring helpers: step forward, step back, offset from a base
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? IDX_LAST : i - IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(off);
    if (s >= SUM_DEPTH) s = s - SUM_DEPTH;
    return s[IdxW-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] mem_q;

  bk_state_t       state, state_next;
  logic [IdxW-1:0] front_idx, front_idx_next;
  logic [CntW-1:0] count, count_next;
  logic [IdxW-1:0] dump_ptr, dump_ptr_next;
  logic [CntW-1:0] dump_left, dump_left_next;

  logic       res_valid;
  logic [1:0] res_status;
  logic       res_last;
  logic       res_mem;

  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;
  logic                     emit;
  status_t                  emit_status;
  logic                     emit_last;
  logic                     full;
  logic                     empty;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (take && work.op == OP_DUMP && count > CNT_ONE) state_next = BK_DUMP;
      BK_DUMP: if (dump_left == CNT_ONE) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Execute the head command or one dump step
  always_comb begin
    take           = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = front_idx;
    rd_en          = 1'b0;
    rd_addr        = front_idx;
    emit           = 1'b0;
    emit_status    = ST_OK;
    emit_last      = 1'b1;
    front_idx_next = front_idx;
    count_next     = count;
    dump_ptr_next  = dump_ptr;
    dump_left_next = dump_left;
    unique case (state)
      BK_IDLE: begin
        if (work.valid) begin
          take = 1'b1;
          emit = 1'b1;
          unique case (work.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                emit_status = ST_OVER;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = idx_dec(front_idx);
                front_idx_next = idx_dec(front_idx);
                count_next     = count + CNT_ONE;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                emit_status = ST_OVER;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(front_idx, count);
                count_next = count + CNT_ONE;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                emit_status = ST_UNDER;
              end else begin
                rd_en          = 1'b1;
                rd_addr        = front_idx;
                front_idx_next = idx_inc(front_idx);
                count_next     = count - CNT_ONE;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                emit_status = ST_UNDER;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ring_add(front_idx, count - CNT_ONE);
                count_next = count - CNT_ONE;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                emit_status = ST_EMPTY;
              end else begin
                rd_en          = 1'b1;
                rd_addr        = front_idx;
                emit_last      = (count == CNT_ONE);
                dump_ptr_next  = idx_inc(front_idx);
                dump_left_next = count - CNT_ONE;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      BK_DUMP: begin
        emit           = 1'b1;
        rd_en          = 1'b1;
        rd_addr        = dump_ptr;
        emit_last      = (dump_left == CNT_ONE);
        dump_ptr_next  = idx_inc(dump_ptr);
        dump_left_next = dump_left - CNT_ONE;
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      front_idx <= '0;
      count     <= '0;
      dump_left <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      count     <= count_next;
      dump_left <= dump_left_next;
      res_valid <= emit;
    end
  end

  // Result word and dump pointer
  always_ff @(posedge clk) begin
    dump_ptr   <= dump_ptr_next;
    res_status <= emit_status;
    res_last   <= emit_last;
    res_mem    <= rd_en;
  end

  // Element store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= work.value;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  assign strobe         = res_valid;
  assign result.status  = res_status;
  assign result.element = res_mem ? mem_q : '0;
  assign result.last    = res_last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("element count above depth");
  a_dump_left: assert property (@(posedge clk) disable iff (rst)
      state == BK_DUMP |-> dump_left != '0)
    else $error("dump running with nothing left");
  a_no_take_dump: assert property (@(posedge clk) disable iff (rst)
      state == BK_DUMP |-> !take)
    else $error("command taken during dump");
  a_read_emits: assert property (@(posedge clk) disable iff (rst)
      rd_en |=> res_valid && res_mem)
    else $error("store read without result");
`endif

endmodule

/* rtl/core/double_ended_queue_store_top.sv */
// Bounded double-ended queue of signed 32-bit words in a ring of DEPTH
// entries. Drive start with a command word while busy is low; kinds are push
// front, push back, pop front, pop back and dump, other kind codes are
// dropped silently. A two-entry command queue sits in front of the executing
// back end, so busy rises only when both entries wait. Each result appears on
// result for one cycle with strobe high and cannot be held off; a command's
// first result comes in the cycle after the back end takes the command.
// With the back end idle, a command passes the command queue and then the
// result registers before its first result shows. Push and pop commands
// sustain one per cycle while no dump holds the back end; a dump holds the
// back end until every stored element is read, since the element store has
// a single registered read port. Every command gives one result, a non-empty
// dump one per element, and the final result of each command has last set.
module double_ended_queue_store_top #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dqs_pkg::cmd_t cmd,
  output logic          strobe,
  output dqs_pkg::res_t result
);
  import dqs_pkg::*;

  work_t work;
  logic  take;

  dqs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .work  (work),
    .take  (take)
  );

  dqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .work   (work),
    .take   (take),
    .strobe (strobe),
    .result (result)
  );

endmodule
